// ===== rtl/core/fnl_pkg.sv =====
// Shared types, codes and byte-format helpers for the feedback nibble link.
`timescale 1ns / 1ps
package fnl_pkg;

  localparam int unsigned FNL_QUEUE_DEPTH = 16;

  localparam logic [7:0] ADDR_MAX = 8'd128;
  localparam logic [7:0] HALF_BIT = 8'b0000_1000;

  // configuration register indexes
  localparam logic [1:0] CFG_STATION_ADDR = 2'd0;
  localparam logic [1:0] CFG_MODULE_KIND  = 2'd1;
  localparam logic [1:0] CFG_REPEAT_COUNT = 2'd2;

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SEND4 = 2'd1;
  localparam logic [1:0] MODE_SEND8 = 2'd2;

  // module kinds
  localparam logic [1:0] KIND_SWITCH   = 2'd1;
  localparam logic [1:0] KIND_FEEDBACK = 2'd2;

  typedef enum logic [2:0] {
    PH_UNSYNC    = 3'd0,
    PH_FB_NEED   = 3'd1,
    PH_FIRST     = 3'd2,
    PH_SECOND    = 3'd3,
    PH_CONNECTED = 3'd4
  } link_phase_e;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic [7:0] wdata;
  } fnl_qcmd_t;

  // value bit 0 lands in byte bit 7
  function automatic logic [7:0] fnl_rev4(input logic [3:0] v);
    return {v[0], v[1], v[2], v[3], 4'b0000};
  endfunction

  // add type bits and force odd parity in bit 0
  function automatic logic [7:0] fnl_finish(input logic [7:0] v, input logic [1:0] kind);
    logic [7:0] b;
    b = v;
    if (kind == KIND_SWITCH) b[2] = 1'b1;
    if (kind == KIND_FEEDBACK) b[1] = 1'b1;
    b[0] = ~(^b[7:1]);
    return b;
  endfunction

endpackage

// ===== rtl/core/fnl_queue.sv =====
// Byte FIFO: synchronous memory with head, tail and fill count.
`timescale 1ns / 1ps
module fnl_queue #(
  parameter int unsigned DEPTH = fnl_pkg::FNL_QUEUE_DEPTH,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fnl_pkg::fnl_qcmd_t   cmd_i,
  output logic [CntW-1:0]      count_o,
  output logic [7:0]           rd_data_o
);
  import fnl_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  logic [7:0]      mem_q [DEPTH];
  logic [7:0]      rd_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else begin
      if (cmd_i.push) tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      if (cmd_i.pop) head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      count_d = count_q + CntW'(cmd_i.push) - CntW'(cmd_i.pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // read data holds until the next pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[tail_q] <= cmd_i.wdata;
    if (cmd_i.pop) rd_q <= mem_q[head_q];
  end

  assign count_o   = count_q;
  assign rd_data_o = rd_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("pop from empty queue");

  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> count_q != CntW'(DEPTH))
    else $error("push into full queue");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> count_q == '0)
    else $error("flush left bytes queued");

endmodule

// ===== rtl/core/fnl_ctrl.sv =====
// Link state machine, push sequencer, result stage and output register.
`timescale 1ns / 1ps
module fnl_ctrl #(
  parameter int unsigned DEPTH = fnl_pkg::FNL_QUEUE_DEPTH,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_mode_i,
  input  logic [7:0]           in_data_i,
  input  logic                 in_upper_i,
  input  logic                 in_sig_i,
  input  logic                 in_busy_i,
  output fnl_pkg::fnl_qcmd_t   qcmd_o,
  input  logic [CntW-1:0]      q_count_i,
  input  logic [7:0]           q_rd_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_tx_valid_o,
  output logic [7:0]           out_tx_byte_o,
  output logic [7:0]           out_tx_addr_o,
  output logic [2:0]           out_state_o,
  output logic                 out_fb_o,
  output logic [CntW-1:0]      out_level_o,
  output logic                 out_ovf_o,
  output logic                 out_cancel_o
);
  import fnl_pkg::*;

  logic [7:0] addr_q;
  logic [1:0] kind_q, rep_q;

  link_phase_e phase_q, phase_d;
  logic        fb_q, fb_d;

  logic [3:0] push_left_q, push_left_d;
  logic [7:0] push_lo_q, push_hi_q;
  logic       push_pair_q, push_sel_q, ovf_q;

  logic            b_valid_q, b_txv_q, b_fb_q, b_ovf_q, b_cancel_q;
  logic [7:0]      b_addr_q;
  link_phase_e     b_phase_q;
  logic [CntW-1:0] b_level_q;

  logic            o_valid_q, o_txv_q, o_fb_q, o_ovf_q, o_cancel_q;
  logic [7:0]      o_byte_q, o_addr_q;
  link_phase_e     o_phase_q;
  logic [CntW-1:0] o_level_q;

  logic b_move, b_load_ok, b_load, push_active, push_last, push_fire, push_ok;
  logic accept, is_tick, is_send4, is_send8, q_full, hand_ok;
  logic tick_pop, tick_flush;
  logic [7:0] lo_byte, hi_byte;
  logic [3:0] rep_n;

  assign b_move      = b_valid_q && (!o_valid_q || out_ready_i);
  assign b_load_ok   = !b_valid_q || b_move;
  assign push_active = push_left_q != 4'd0;
  assign push_last   = push_left_q == 4'd1;
  // no item enters while bytes are still being written
  assign in_ready_o  = !push_active && b_load_ok;
  assign accept      = in_valid_i && in_ready_o;
  assign is_tick     = accept && (in_mode_i == MODE_TICK);
  assign is_send4    = accept && (in_mode_i == MODE_SEND4);
  assign is_send8    = accept && (in_mode_i == MODE_SEND8);
  assign q_full      = q_count_i == CntW'(DEPTH);
  assign push_fire   = push_active && (!push_last || b_load_ok);
  assign push_ok     = push_fire && !q_full;
  assign hand_ok     = (q_count_i != '0) && !in_busy_i &&
                       (addr_q != 8'd0) && (addr_q <= ADDR_MAX);

  // link machine: outputs
  always_comb begin
    tick_pop   = 1'b0;
    tick_flush = 1'b0;
    if (is_tick) begin
      if (!in_sig_i) begin
        tick_flush = 1'b1;
      end else begin
        unique case (phase_q)
          PH_UNSYNC, PH_FB_NEED: tick_pop = 1'b0;
          default:               tick_pop = hand_ok;
        endcase
      end
    end
  end

  // link machine: next state
  always_comb begin
    phase_d = phase_q;
    fb_d    = fb_q;
    if (is_send8) fb_d = 1'b0;
    if (is_tick) begin
      if (!in_sig_i) begin
        phase_d = PH_UNSYNC;
      end else begin
        unique case (phase_q)
          PH_UNSYNC: begin
            phase_d = PH_FB_NEED;
            fb_d    = 1'b1;
          end
          PH_FB_NEED: if (!fb_q) phase_d = PH_FIRST;
          PH_FIRST:   if (tick_pop) phase_d = PH_SECOND;
          PH_SECOND:  if (tick_pop) phase_d = PH_CONNECTED;
          default:    phase_d = phase_q;
        endcase
      end
    end
  end

  assign lo_byte = fnl_finish(fnl_rev4(in_data_i[3:0]) |
                              {4'b0000, in_upper_i && is_send4, 3'b000}, kind_q);
  assign hi_byte = fnl_finish(fnl_rev4(in_data_i[7:4]) | HALF_BIT, kind_q);
  assign rep_n   = {2'b00, rep_q} + 4'd1;

  always_comb begin
    push_left_d = push_left_q;
    if (is_send4) push_left_d = rep_n;
    else if (is_send8) push_left_d = {rep_n[2:0], 1'b0};
    else if (push_fire) push_left_d = push_left_q - 4'd1;
  end

  assign qcmd_o.push  = push_ok;
  assign qcmd_o.pop   = tick_pop;
  assign qcmd_o.flush = tick_flush;
  assign qcmd_o.wdata = push_sel_q ? push_hi_q : push_lo_q;

  assign b_load = (push_fire && push_last) || (accept && !is_send4 && !is_send8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= 8'd0;
      kind_q      <= KIND_FEEDBACK;
      rep_q       <= 2'd0;
      phase_q     <= PH_UNSYNC;
      fb_q        <= 1'b0;
      push_left_q <= 4'd0;
      b_valid_q   <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STATION_ADDR: addr_q <= cfg_data_i;
          CFG_MODULE_KIND:  kind_q <= cfg_data_i[1:0];
          CFG_REPEAT_COUNT: rep_q  <= cfg_data_i[1:0];
          default:          addr_q <= addr_q;
        endcase
      end
      phase_q     <= phase_d;
      fb_q        <= fb_d;
      push_left_q <= push_left_d;
      b_valid_q   <= b_load || (b_valid_q && !b_move);
      o_valid_q   <= b_move || (o_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_send4 || is_send8) begin
      push_lo_q   <= lo_byte;
      push_hi_q   <= hi_byte;
      push_pair_q <= is_send8;
      push_sel_q  <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (push_fire) begin
      // alternate low and high nibble for eight-bit sends
      push_sel_q <= push_pair_q && !push_sel_q;
      ovf_q      <= ovf_q || q_full;
    end

    if (push_fire && push_last) begin
      b_txv_q    <= 1'b0;
      b_addr_q   <= 8'd0;
      b_phase_q  <= phase_q;
      b_fb_q     <= fb_q;
      b_level_q  <= q_count_i + CntW'(push_ok);
      b_ovf_q    <= ovf_q || q_full;
      b_cancel_q <= 1'b0;
    end else if (b_load) begin
      b_txv_q    <= tick_pop;
      b_addr_q   <= tick_pop ? addr_q : 8'd0;
      b_phase_q  <= phase_d;
      b_fb_q     <= fb_d;
      b_level_q  <= tick_flush ? '0 : q_count_i - CntW'(tick_pop);
      b_ovf_q    <= 1'b0;
      b_cancel_q <= tick_flush;
    end

    // queue read data arrives in the cycle after the pop
    if (b_move) begin
      o_txv_q    <= b_txv_q;
      o_byte_q   <= b_txv_q ? q_rd_data_i : 8'd0;
      o_addr_q   <= b_addr_q;
      o_phase_q  <= b_phase_q;
      o_fb_q     <= b_fb_q;
      o_level_q  <= b_level_q;
      o_ovf_q    <= b_ovf_q;
      o_cancel_q <= b_cancel_q;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign out_tx_valid_o = o_txv_q;
  assign out_tx_byte_o  = o_byte_q;
  assign out_tx_addr_o  = o_addr_q;
  assign out_state_o    = o_phase_q;
  assign out_fb_o       = o_fb_q;
  assign out_level_o    = o_level_q;
  assign out_ovf_o      = o_ovf_q;
  assign out_cancel_o   = o_cancel_q;

  a_push_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_active |-> !in_ready_o)
    else $error("input accepted during push sequence");

  a_write_read_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcmd_o.push |-> !qcmd_o.pop && !qcmd_o.flush)
    else $error("queue write overlaps read or flush");

  a_handoff_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_txv_q |-> (o_addr_q != 8'd0) && (o_addr_q <= ADDR_MAX))
    else $error("hand-off with address out of range");

endmodule

// ===== rtl/core/feedback_nibble_link_top.sv =====
// Top level of the feedback nibble link transmitter.
`timescale 1ns / 1ps
// Feedback nibble link: each input beat is a tick (tuser mode 0), a send of four or
// eight feedback bits (mode 1 or 2) or ignored (mode 3); every input beat yields
// exactly one result beat. Sends format nibble bytes and write them into a byte FIFO
// held in a synchronous memory; ticks run the connection machine and pop the oldest
// byte to the serial sender. A tick or an ignored mode-3 beat is accepted every cycle
// unless a send is being written or the output stalls; its result passes the result
// stage and the output register. A send writes (repeat_count+1) bytes for four bits
// or 2*(repeat_count+1) bytes for eight bits, as the FIFO memory takes one write per
// cycle. The FIFO memory needs no clearing pass after reset. Configuration is
// written through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
module feedback_nibble_link_top #(
  parameter int unsigned QUEUE_DEPTH = fnl_pkg::FNL_QUEUE_DEPTH,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OutFieldsW = 22 + CntW,
  localparam int unsigned OutW = ((OutFieldsW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // data_value, upper_half, signal_ok, transmitter_busy, zero fill
  input  logic [15:0]     s_axis_tdata,
  // mode
  input  logic [1:0]      s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // tx_byte, tx_address, link_state, feedback_wanted, queue_level, overflow,
  // cancel_pending, zero fill
  output logic [OutW-1:0] m_axis_tdata,
  // tx_valid
  output logic            m_axis_tuser
);
  import fnl_pkg::*;

  fnl_qcmd_t       qcmd;
  logic [CntW-1:0] q_count, out_level;
  logic [7:0]      q_rd_data, out_byte, out_addr;
  logic [2:0]      out_state;
  logic            out_fb, out_ovf, out_cancel;

  fnl_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_mode_i      (s_axis_tuser),
    .in_data_i      (s_axis_tdata[7:0]),
    .in_upper_i     (s_axis_tdata[8]),
    .in_sig_i       (s_axis_tdata[9]),
    .in_busy_i      (s_axis_tdata[10]),
    .qcmd_o         (qcmd),
    .q_count_i      (q_count),
    .q_rd_data_i    (q_rd_data),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_tx_valid_o (m_axis_tuser),
    .out_tx_byte_o  (out_byte),
    .out_tx_addr_o  (out_addr),
    .out_state_o    (out_state),
    .out_fb_o       (out_fb),
    .out_level_o    (out_level),
    .out_ovf_o      (out_ovf),
    .out_cancel_o   (out_cancel)
  );

  fnl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (qcmd),
    .count_o   (q_count),
    .rd_data_o (q_rd_data)
  );

  assign m_axis_tdata = OutW'({out_cancel, out_ovf, out_level, out_fb, out_state,
                               out_addr, out_byte});

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the feedback nibble link transmitter.
`timescale 1ns / 1ps
module tb;
  import fnl_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned DIR_N = 25;

  typedef enum bit {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct packed {
    logic       busy;
    logic       sig;
    logic       upper;
    logic [7:0] data;
  } beat_in_t;

  // same order as {m_axis_tuser, m_axis_tdata[26:0]}
  typedef struct packed {
    logic       txv;
    logic       cancel;
    logic       ovf;
    logic [4:0] level;
    logic       fb;
    logic [2:0] phase;
    logic [7:0] tx_addr;
    logic [7:0] tx_byte;
  } link_res_t;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] sel;    // mode of a beat, or register index
    logic [7:0] val;    // data value, or register value
    logic       upper;
    logic       sig;
    logic       busy;
    bit         typed;
    link_res_t  res;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [7:0]      cfg_data_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata;
  logic [1:0]      s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [31:0]     m_axis_tdata;
  logic            m_axis_tuser;

  // link model state
  logic [7:0]  m_addr;
  logic [1:0]  m_kind;
  logic [1:0]  m_repeat;
  link_phase_e m_phase;
  logic        m_fb;
  logic [7:0]  m_fifo[$];

  link_res_t   awaited_results[$];
  int unsigned errors;
  int unsigned stall_cycles;
  bit          no_idle;

  dir_row_t dir_tab [DIR_N] = '{
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 5'd0, 1'b0, PH_UNSYNC, 8'd0, 8'd0}},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 5'd0, 1'b1, PH_FB_NEED, 8'd0, 8'd0}},
    '{ROW_BEAT, MODE_TICK, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1,
      '{1'b0, 1'b0, 1'b0, 5'd0, 1'b1, PH_FB_NEED, 8'd0, 8'd0}},
    '{ROW_BEAT, MODE_IGNORED, 8'hff, 1'b1, 1'b0, 1'b1, 1'b1,
      '{1'b0, 1'b0, 1'b0, 5'd0, 1'b1, PH_FB_NEED, 8'd0, 8'd0}},
    '{ROW_BEAT, MODE_SEND8, 8'hff, 1'b0, 1'b1, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 5'd2, 1'b0, PH_FB_NEED, 8'd0, 8'd0}},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 5'd2, 1'b0, PH_FIRST, 8'd0, 8'd0}},
    // address zero: nothing leaves the queue
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 5'd2, 1'b0, PH_FIRST, 8'd0, 8'd0}},
    '{ROW_REG, CFG_STATION_ADDR, 8'd128, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, '0},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_SEND4, 8'h0f, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BEAT, MODE_SEND4, 8'hf0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_REG, CFG_REPEAT_COUNT, 8'd3, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_SEND8, 8'ha5, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    // fills the queue past its depth
    '{ROW_BEAT, MODE_SEND8, 8'h5a, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_BEAT, MODE_SEND4, 8'h09, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_REG, CFG_MODULE_KIND, 8'd3, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_REG, CFG_STATION_ADDR, 8'd129, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    // signal loss flushes the queue, feedback flag already clear
    '{ROW_BEAT, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 5'd0, 1'b0, PH_UNSYNC, 8'd0, 8'd0}},
    '{ROW_REG, CFG_MODULE_KIND, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_BEAT, MODE_SEND4, 8'h03, 1'b0, 1'b1, 1'b1, 1'b0, '0}
  };

  logic [7:0] phase_addr [NUM_PHASES] = '{8'd1, 8'd128, 8'd0, 8'd77, 8'd129, 8'd255, 8'd42,
                                          8'd100};
  logic [1:0] phase_rep [NUM_PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};

  feedback_nibble_link_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // nibble reversed into the top bits, half bit, type bits, odd parity
  function automatic logic [7:0] nibble_byte(input logic [3:0] v, input logic half);
    logic [7:0] b;
    b = {v[0], v[1], v[2], v[3], half, m_kind == KIND_SWITCH, m_kind == KIND_FEEDBACK, 1'b0};
    b[0] = ~(^b);
    return b;
  endfunction

  function automatic bit queue_byte(input logic [7:0] b);
    if (m_fifo.size() >= FNL_QUEUE_DEPTH) return 1'b0;
    m_fifo.push_back(b);
    return 1'b1;
  endfunction

  function automatic bit hand_off(input logic busy, output logic [7:0] b,
                                  output logic [7:0] a);
    b = '0;
    a = '0;
    if (m_fifo.size() == 0 || busy || m_addr == 8'd0 || m_addr > ADDR_MAX) return 1'b0;
    b = m_fifo.pop_front();
    a = m_addr;
    return 1'b1;
  endfunction

  function automatic link_res_t link_response(input logic [1:0] mode, input beat_in_t it);
    link_res_t r;
    r = '0;
    case (mode)
      MODE_SEND4: begin
        for (int n = 0; n <= m_repeat; n++)
          if (!queue_byte(nibble_byte(it.data[3:0], it.upper))) r.ovf = 1'b1;
      end
      MODE_SEND8: begin
        m_fb = 1'b0;
        for (int n = 0; n <= m_repeat; n++) begin
          if (!queue_byte(nibble_byte(it.data[3:0], 1'b0))) r.ovf = 1'b1;
          if (!queue_byte(nibble_byte(it.data[7:4], 1'b1))) r.ovf = 1'b1;
        end
      end
      MODE_TICK: begin
        if (!it.sig) begin
          m_phase = PH_UNSYNC;
          m_fifo.delete();
          r.cancel = 1'b1;
        end else begin
          case (m_phase)
            PH_UNSYNC: begin
              m_phase = PH_FB_NEED;
              m_fb = 1'b1;
            end
            PH_FB_NEED: begin
              if (!m_fb) m_phase = PH_FIRST;
            end
            PH_FIRST: begin
              r.txv = hand_off(it.busy, r.tx_byte, r.tx_addr);
              if (r.txv) m_phase = PH_SECOND;
            end
            PH_SECOND: begin
              r.txv = hand_off(it.busy, r.tx_byte, r.tx_addr);
              if (r.txv) m_phase = PH_CONNECTED;
            end
            default: begin
              r.txv = hand_off(it.busy, r.tx_byte, r.tx_addr);
            end
          endcase
        end
      end
      default: ;
    endcase
    r.phase = m_phase;
    r.fb = m_fb;
    r.level = 5'(m_fifo.size());
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  task automatic drive_beat(input logic [1:0] mode, input beat_in_t it, input bit typed,
                            input link_res_t typed_res);
    link_res_t r;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 23) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'b0, it};
    s_axis_tuser = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    r = link_response(mode, it);
    awaited_results.push_back(typed ? typed_res : r);
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_STATION_ADDR: m_addr = val;
      CFG_MODULE_KIND:  m_kind = val[1:0];
      CFG_REPEAT_COUNT: m_repeat = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    link_res_t e;
    link_res_t a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a = {m_axis_tuser, m_axis_tdata[26:0]};
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual %h", $time, a);
      end else begin
        e = awaited_results.pop_front();
        check_field("tx_valid", e.txv, a.txv);
        check_field("tx_byte", e.tx_byte, a.tx_byte);
        check_field("tx_address", e.tx_addr, a.tx_addr);
        check_field("link_state", e.phase, a.phase);
        check_field("feedback_wanted", e.fb, a.fb);
        check_field("queue_level", e.level, a.level);
        check_field("overflow", e.ovf, a.ovf);
        check_field("cancel_pending", e.cancel, a.cancel);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress, run stopped", $time);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    beat_in_t   it;
    logic [1:0] mode;
    int unsigned pick;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    errors = 0;
    stall_cycles = 0;
    no_idle = 1'b0;
    m_addr = 8'd0;
    m_kind = KIND_FEEDBACK;
    m_repeat = 2'd0;
    m_phase = PH_UNSYNC;
    m_fb = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        write_reg(dir_tab[i].sel, dir_tab[i].val);
      end else begin
        it = '{busy: dir_tab[i].busy, sig: dir_tab[i].sig, upper: dir_tab[i].upper,
               data: dir_tab[i].val};
        drive_beat(dir_tab[i].sel, it, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_STATION_ADDR, phase_addr[p]);
      write_reg(CFG_MODULE_KIND, 8'(p % 4));
      write_reg(CFG_REPEAT_COUNT, {6'b0, phase_rep[p]});
      no_idle = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 48) mode = MODE_TICK;
        else if (pick < 70) mode = MODE_SEND4;
        else if (pick < 96) mode = MODE_SEND8;
        else mode = MODE_IGNORED;
        it.data = 8'($urandom_range(255));
        it.upper = 1'($urandom_range(1));
        // keep the link up most of the time so the connected state is reached
        it.sig = (mode == MODE_TICK) ? ($urandom_range(99) >= 3) : 1'($urandom_range(1));
        it.busy = $urandom_range(99) < 25;
        drive_beat(mode, it, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
